// ----- hdl/lgd_pkg.sv -----
// Shared codes, constants, types and helper functions of the LED gamma dither renderer.
package lgd_pkg;

	// item modes
	localparam logic [1:0] MODE_RENDER = 2'd0;
	localparam logic [1:0] MODE_LOAD   = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	// gamma table select
	localparam logic [1:0] SEL_RED   = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_RGBW   = 2'd0;
	localparam logic [1:0] REG_DITHER = 2'd1;
	localparam logic [1:0] REG_SEED   = 2'd2;

	// channel numbers in the order noise is drawn
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;
	localparam logic [1:0] CH_WHITE = 2'd3;

	// channel tags in the order bytes leave the block
	localparam logic [1:0] TAG_BLUE  = 2'd0;
	localparam logic [1:0] TAG_RED   = 2'd1;
	localparam logic [1:0] TAG_GREEN = 2'd2;
	localparam logic [1:0] TAG_WHITE = 2'd3;

	localparam logic [31:0] SEED_DEFAULT = 32'd2463534242;
	localparam logic [15:0] MID_LOW      = 16'd256;
	localparam logic [15:0] MID_HIGH     = 16'd65279;
	localparam logic [31:0] FULL_SCALE   = 32'(255 << 8);
	localparam logic [31:0] ACC_MAX      = 32'h7FFF_FFFF;
	localparam logic [16:0] NOISE_BIAS   = 17'd64;
	localparam logic [23:0] Q_TOP        = 24'd255;

	// result slots in the output buffer
	localparam int SLOTS = 3;
	localparam logic [1:0] SLOT_LAST = 2'(SLOTS - 1);

	typedef logic [1:0] slot_t;

	// one channel of one item, sequencer to dither pipe
	typedef struct packed {
		logic        valid;
		logic        clear;
		logic        dither;
		logic [1:0]  ch;
		logic [15:0] value;
		slot_t       slot;
		logic        last;
	} chan_req_t;

	// one finished byte, dither pipe to output buffer
	typedef struct packed {
		logic       valid;
		slot_t      slot;
		logic [1:0] tag;
		logic [7:0] data;
		logic       last;
	} byte_wr_t;

	// claim of a result slot for a render item
	typedef struct packed {
		logic  valid;
		slot_t slot;
		logic  four;
	} slot_alloc_t;

	// one xorshift32 step
	function automatic logic [31:0] xs_step(input logic [31:0] s);
		logic [31:0] t;
		t = s ^ (s << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

	// map a channel number to its output tag
	function automatic logic [1:0] chan_tag(input logic [1:0] ch);
		logic [1:0] tag;
		unique case (ch)
			CH_RED:   tag = TAG_RED;
			CH_GREEN: tag = TAG_GREEN;
			CH_BLUE:  tag = TAG_BLUE;
			CH_WHITE: tag = TAG_WHITE;
		endcase
		return tag;
	endfunction

	// advance a slot pointer around the ring
	function automatic slot_t slot_next(input slot_t s);
		return (s == SLOT_LAST) ? slot_t'(0) : slot_t'(s + 2'd1);
	endfunction

endpackage

// ----- hdl/lgd_gamma_store.sv -----
// Red, green and blue gamma tables with one write port and a registered three-way read.
module lgd_gamma_store (
	input  logic        clk,
	input  logic        we,
	input  logic [1:0]  wsel,
	input  logic [7:0]  waddr,
	input  logic [15:0] wdata,
	input  logic        re,
	input  logic [7:0]  raddr_red,
	input  logic [7:0]  raddr_green,
	input  logic [7:0]  raddr_blue,
	output logic [15:0] rdata_red,
	output logic [15:0] rdata_green,
	output logic [15:0] rdata_blue
);
	import lgd_pkg::*;

	logic [15:0] tab_red   [256];
	logic [15:0] tab_green [256];
	logic [15:0] tab_blue  [256];
	logic [15:0] rd_red_q;
	logic [15:0] rd_green_q;
	logic [15:0] rd_blue_q;

	// write the selected table, drop select three
	always_ff @(posedge clk) begin
		if (we && wsel == SEL_RED) begin
			tab_red[waddr] <= wdata;
		end
		if (we && wsel == SEL_GREEN) begin
			tab_green[waddr] <= wdata;
		end
		if (we && wsel == SEL_BLUE) begin
			tab_blue[waddr] <= wdata;
		end
	end

	// read all three tables, hold the data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rd_red_q   <= tab_red[raddr_red];
			rd_green_q <= tab_green[raddr_green];
			rd_blue_q  <= tab_blue[raddr_blue];
		end
	end

	assign rdata_red   = rd_red_q;
	assign rdata_green = rd_green_q;
	assign rdata_blue  = rd_blue_q;

endmodule

// ----- hdl/lgd_dither_pipe.sv -----
// Accumulator memory with its read-modify-write dither pipeline, noise generator and clearing pass.
module lgd_dither_pipe #(
	parameter int WORD_AW = 12,
	parameter int WORDS   = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lgd_pkg::chan_req_t req,
	input  logic [WORD_AW-1:0] req_addr,
	input  logic               seed_load,
	input  logic [31:0]        seed_value,
	output lgd_pkg::byte_wr_t  wr,
	output logic               clearing
);
	import lgd_pkg::*;

	localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

	logic [31:0] acc_mem [WORDS];
	logic [31:0] acc_rd_q;

	logic               valid_s2;
	chan_req_t          req_s2;
	logic [WORD_AW-1:0] addr_s2;

	logic               valid_s3;
	logic               clear_s3;
	logic               dither_s3;
	logic [1:0]         ch_s3;
	slot_t              slot_s3;
	logic               last_s3;
	logic [WORD_AW-1:0] addr_s3;
	logic [31:0]        acc_s3;
	logic [7:0]         hi_s3;

	logic [31:0]        noise_q;
	logic               clr_busy_q;
	logic [WORD_AW-1:0] clr_addr_q;

	logic        mid;
	logic [31:0] noise_next;
	logic [16:0] val_adj;
	logic [32:0] sum;
	logic [31:0] acc_sat;

	logic               q_low;
	logic               q_high;
	logic [7:0]         dith_byte;
	logic [31:0]        acc_new;
	logic               acc_we;
	logic [WORD_AW-1:0] acc_waddr;
	logic [31:0]        acc_wdata;

	// read the accumulator of the issued channel
	always_ff @(posedge clk) begin
		if (req.valid) begin
			acc_rd_q <= acc_mem[req_addr];
		end
	end

	// write back a result or a cleared entry
	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= req.valid;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		req_s2  <= req;
		addr_s2 <= req_addr;
	end

	// add noise in the mid range, accumulate with saturation
	always_comb begin
		mid = valid_s2 && !req_s2.clear && req_s2.dither
			&& (req_s2.value > MID_LOW) && (req_s2.value < MID_HIGH);
		noise_next = xs_step(noise_q);
		if (mid) begin
			val_adj = {1'b0, req_s2.value} + {10'd0, noise_next[8:2]} - NOISE_BIAS;
		end else begin
			val_adj = {1'b0, req_s2.value};
		end
		sum = {acc_rd_q[31], acc_rd_q} + {16'd0, val_adj};
		acc_sat = (!sum[32] && sum[31]) ? ACC_MAX : sum[31:0];
	end

	// advance the noise generator once per draw, reload on a seed write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q <= SEED_DEFAULT;
		end else if (seed_load) begin
			noise_q <= seed_value;
		end else if (mid) begin
			noise_q <= noise_next;
		end
	end

	// stage 3 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// stage 3 payload
	always_ff @(posedge clk) begin
		clear_s3  <= req_s2.clear;
		dither_s3 <= req_s2.dither;
		ch_s3     <= req_s2.ch;
		slot_s3   <= req_s2.slot;
		last_s3   <= req_s2.last;
		addr_s3   <= addr_s2;
		acc_s3    <= acc_sat;
		hi_s3     <= req_s2.value[15:8];
	end

	// quantize: clamp at zero and full scale, keep the remainder
	always_comb begin
		q_low  = acc_s3[31] || (acc_s3[31:8] == 24'd0);
		q_high = !acc_s3[31] && (acc_s3[31:8] >= Q_TOP);
		priority if (q_low) begin
			dith_byte = 8'd0;
			acc_new   = acc_s3;
		end else if (q_high) begin
			dith_byte = 8'hFF;
			acc_new   = acc_s3 - FULL_SCALE;
		end else begin
			dith_byte = acc_s3[15:8];
			acc_new   = {24'd0, acc_s3[7:0]};
		end
	end

	// share the write port between the clearing pass and write-back
	always_comb begin
		acc_we    = clr_busy_q || (valid_s3 && (clear_s3 || dither_s3));
		acc_waddr = clr_busy_q ? clr_addr_q : addr_s3;
		acc_wdata = (clr_busy_q || clear_s3) ? 32'd0 : acc_new;
	end

	// sweep every accumulator word to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_WORD) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// hand the finished byte to the output buffer
	always_comb begin
		wr.valid = valid_s3 && !clear_s3;
		wr.slot  = slot_s3;
		wr.tag   = chan_tag(ch_s3);
		wr.data  = dither_s3 ? dith_byte : hi_s3;
		wr.last  = last_s3;
	end

	assign clearing = clr_busy_q;

endmodule

// ----- hdl/lgd_out_buf.sv -----
// Three-slot result buffer that collects each pixel's bytes and sends them in link order.
module lgd_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lgd_pkg::slot_alloc_t alloc,
	output logic                 alloc_ok,
	output lgd_pkg::slot_t       alloc_slot,
	input  lgd_pkg::byte_wr_t    wr,
	output logic                 byte_valid,
	input  logic                 byte_stall,
	output logic [7:0]           out_byte,
	output logic [1:0]           channel_tag,
	output logic                 last_of_pixel
);
	import lgd_pkg::*;

	logic [SLOTS-1:0] busy_q;
	logic [SLOTS-1:0] full_q;
	logic [SLOTS-1:0] busy_d;
	logic [SLOTS-1:0] full_d;
	logic [SLOTS-1:0] four_q;
	logic [7:0]       data_q [SLOTS][4];
	slot_t            wp_q;
	slot_t            rp_q;
	logic [1:0]       emit_q;
	logic             emit_last;
	logic             take;

	assign alloc_ok   = !busy_q[wp_q];
	assign alloc_slot = wp_q;

	assign emit_last = emit_q == (four_q[rp_q] ? TAG_WHITE : TAG_GREEN);
	assign take      = full_q[rp_q] && !byte_stall;

	// claim, fill and release slot flags
	always_comb begin
		busy_d = busy_q;
		full_d = full_q;
		if (alloc.valid) begin
			busy_d[alloc.slot] = 1'b1;
		end
		if (wr.valid && wr.last) begin
			full_d[wr.slot] = 1'b1;
		end
		if (take && emit_last) begin
			busy_d[rp_q] = 1'b0;
			full_d[rp_q] = 1'b0;
		end
	end

	// advance the pointers and the byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			full_q <= '0;
			wp_q   <= '0;
			rp_q   <= '0;
			emit_q <= '0;
		end else begin
			busy_q <= busy_d;
			full_q <= full_d;
			if (alloc.valid) begin
				wp_q <= slot_next(wp_q);
			end
			if (take) begin
				if (emit_last) begin
					rp_q   <= slot_next(rp_q);
					emit_q <= '0;
				end else begin
					emit_q <= emit_q + 2'd1;
				end
			end
		end
	end

	// store the pixel width and the bytes
	always_ff @(posedge clk) begin
		if (alloc.valid) begin
			four_q[alloc.slot] <= alloc.four;
		end
		if (wr.valid) begin
			data_q[wr.slot][wr.tag] <= wr.data;
		end
	end

	assign byte_valid    = full_q[rp_q];
	assign out_byte      = data_q[rp_q][emit_q];
	assign channel_tag   = emit_q;
	assign last_of_pixel = emit_last;

endmodule

// ----- hdl/led_gamma_dither_renderer.sv -----
// Top level: configuration registers, input stage, channel sequencer and the datapath instances.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------------
//  pixel in | pixel_valid / pixel_stall    | mode, led_index, red/green/blue_in, table_*
//  byte out | byte_valid / byte_stall      | out_byte, channel_tag, last_of_pixel
//  config   | APB psel/penable/pwrite      | paddr[3:2] selects register, pwdata/prdata
//
//  Load and dropped items never enter stage 1. Render and clear items occupy the channel
//  sequencer for three channels (RGB render) or four (RGBW render, clear): the accumulator memory
//  has one read and one write port and serves one channel per cycle.
//  A finished pixel's bytes leave one byte per cycle while byte_stall is low.
//  After reset a clearing pass writes all 4*min(MAX_LEDS,1024) accumulator words;
//  pixel_stall stays high meanwhile, APB writes are taken.
//  byte_stall holds the current byte; three result slots let rendering run ahead,
//  and pixel_stall rises once all slots are claimed.
module led_gamma_dither_renderer #(
	parameter int MAX_LEDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [1:0]  mode,
	input  logic [9:0]  led_index,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [1:0]  table_select,
	input  logic [7:0]  table_index,
	input  logic [15:0] table_value,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  channel_tag,
	output logic        last_of_pixel
);
	import lgd_pkg::*;

	localparam int ACC_DEPTH = (MAX_LEDS < 1024) ? MAX_LEDS : 1024;
	localparam int LED_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
	localparam int WORD_AW   = LED_AW + 2;
	localparam int ACC_WORDS = 4 * ACC_DEPTH;
	localparam logic [16:0] LED_LIMIT = 17'(MAX_LEDS);

	logic        rgbw_q;
	logic        dither_q;
	logic [31:0] seed_q;
	logic        cfg_wr;
	logic [1:0]  reg_idx;
	logic [31:0] seed_wval;
	logic        seed_load;

	logic        accept;
	logic        led_ok;
	logic        gamma_we;
	logic        gamma_re;
	logic        s1_enter;
	logic [15:0] g_red;
	logic [15:0] g_green;
	logic [15:0] g_blue;

	logic              valid_s1;
	logic              clear_s1;
	logic [LED_AW-1:0] led_s1;

	logic              seq_valid_q;
	logic [1:0]        seq_ch_q;
	logic              seq_clear_q;
	logic              seq_dither_q;
	logic              seq_four_q;
	logic [LED_AW-1:0] seq_led_q;
	logic [15:0]       seq_val_q [4];
	slot_t             seq_slot_q;
	logic              seq_last;
	logic              take;

	logic [15:0] w_rg;
	logic [15:0] w_min;
	logic [15:0] v_white;

	logic        clearing;
	logic        alloc_ok;
	slot_t       alloc_slot;
	slot_alloc_t alloc;
	chan_req_t   req;
	byte_wr_t    wr;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign reg_idx   = paddr[3:2];
	assign seed_wval = (pwdata == 32'd0) ? SEED_DEFAULT : pwdata;
	assign seed_load = cfg_wr && reg_idx == REG_SEED;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgbw_q   <= 1'b0;
			dither_q <= 1'b1;
			seed_q   <= SEED_DEFAULT;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_RGBW:   rgbw_q   <= pwdata[0];
				REG_DITHER: dither_q <= pwdata[0];
				REG_SEED:   seed_q   <= seed_wval;
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RGBW:   prdata = {31'd0, rgbw_q};
			REG_DITHER: prdata = {31'd0, dither_q};
			REG_SEED:   prdata = seed_q;
			default:    prdata = 32'd0;
		endcase
	end

	// input decode: loads go straight to the tables, render and clear enter stage 1
	assign accept   = pixel_valid && !pixel_stall;
	assign led_ok   = {7'd0, led_index} < LED_LIMIT;
	assign gamma_we = accept && mode == MODE_LOAD;
	assign gamma_re = accept && mode == MODE_RENDER && led_ok;
	assign s1_enter = accept && led_ok && (mode == MODE_RENDER || mode == MODE_CLEAR);

	lgd_gamma_store u_gamma (
		.clk         (clk),
		.we          (gamma_we),
		.wsel        (table_select),
		.waddr       (table_index),
		.wdata       (table_value),
		.re          (gamma_re),
		.raddr_red   (red_in),
		.raddr_green (green_in),
		.raddr_blue  (blue_in),
		.rdata_red   (g_red),
		.rdata_green (g_green),
		.rdata_blue  (g_blue)
	);

	// hand the stage 1 item to the sequencer once the sequencer finishes and, for a render item, a slot is free
	assign seq_last    = seq_ch_q == (seq_four_q ? CH_WHITE : CH_BLUE);
	assign take        = valid_s1 && (!seq_valid_q || seq_last) && (clear_s1 || alloc_ok);
	assign pixel_stall = clearing || (valid_s1 && !take);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_enter) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (s1_enter) begin
			clear_s1 <= mode == MODE_CLEAR;
			led_s1   <= led_index[LED_AW-1:0];
		end
	end

	// common minimum moves into white in RGBW mode
	always_comb begin
		w_rg    = (g_red < g_green) ? g_red : g_green;
		w_min   = (g_blue < w_rg) ? g_blue : w_rg;
		v_white = rgbw_q ? w_min : 16'd0;
	end

	// sequencer control: walk the channels red, green, blue, white
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_valid_q <= 1'b0;
			seq_ch_q    <= CH_RED;
		end else if (take) begin
			seq_valid_q <= 1'b1;
			seq_ch_q    <= CH_RED;
		end else if (seq_valid_q && seq_last) begin
			seq_valid_q <= 1'b0;
		end else if (seq_valid_q) begin
			seq_ch_q <= seq_ch_q + 2'd1;
		end
	end

	// sequencer payload
	always_ff @(posedge clk) begin
		if (take) begin
			seq_clear_q         <= clear_s1;
			seq_dither_q        <= dither_q;
			seq_four_q          <= clear_s1 || rgbw_q;
			seq_led_q           <= led_s1;
			seq_slot_q          <= alloc_slot;
			seq_val_q[CH_RED]   <= g_red - v_white;
			seq_val_q[CH_GREEN] <= g_green - v_white;
			seq_val_q[CH_BLUE]  <= g_blue - v_white;
			seq_val_q[CH_WHITE] <= v_white;
		end
	end

	always_comb begin
		alloc.valid = take && !clear_s1;
		alloc.slot  = alloc_slot;
		alloc.four  = rgbw_q;

		req.valid  = seq_valid_q;
		req.clear  = seq_clear_q;
		req.dither = seq_dither_q;
		req.ch     = seq_ch_q;
		req.value  = seq_val_q[seq_ch_q];
		req.slot   = seq_slot_q;
		req.last   = seq_last;
	end

	lgd_dither_pipe #(
		.WORD_AW (WORD_AW),
		.WORDS   (ACC_WORDS)
	) u_dither (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.req_addr   ({seq_led_q, seq_ch_q}),
		.seed_load  (seed_load),
		.seed_value (seed_wval),
		.wr         (wr),
		.clearing   (clearing)
	);

	lgd_out_buf u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.alloc         (alloc),
		.alloc_ok      (alloc_ok),
		.alloc_slot    (alloc_slot),
		.wr            (wr),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.out_byte      (out_byte),
		.channel_tag   (channel_tag),
		.last_of_pixel (last_of_pixel)
	);

endmodule

// ----- hdl/lgd_port_check.sv -----
// Port-level checks of the LED gamma dither renderer and their bind to the top level.
module lgd_port_check (
	input logic       clk,
	input logic       arst_n,
	input logic       pixel_stall,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] out_byte,
	input logic [1:0] channel_tag,
	input logic       last_of_pixel
);
	import lgd_pkg::*;

	// hold a stalled byte
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(out_byte)
			&& $stable(channel_tag) && $stable(last_of_pixel))
		else $error("stalled byte changed");

	// bytes of one pixel follow each other without a gap, tags counting up
	a_tag_step: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && !last_of_pixel |=> byte_valid
			&& (channel_tag == 2'($past(channel_tag) + 2'd1)))
		else $error("pixel bytes broke sequence");

	// the first byte of a pixel is never its last
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && channel_tag == TAG_BLUE |-> !last_of_pixel)
		else $error("pixel ended on its blue byte");

	// stall input and show no byte right after reset, while the clearing pass runs
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> pixel_stall && !byte_valid)
		else $error("activity right after reset");

endmodule

bind led_gamma_dither_renderer lgd_port_check u_port_check (.*);

// ----- dv/led_gamma_dither_renderer_tb.sv -----
// Self-checking testbench for the LED gamma dither renderer: predicted byte stream vs. DUT.
`timescale 1ns / 100ps

module led_gamma_dither_renderer_tb;
	import lgd_pkg::*;

	localparam int LED_COUNT    = 1024;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 24;
	localparam int END_WAIT     = 20000;
	localparam int PHASE_ITEMS  = 80;

	// codes the block drops without any result
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam logic [1:0] SEL_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [9:0]  led;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [1:0]  sel;
		logic [7:0]  index;
		logic [15:0] value;
	} pixel_item_t;

	typedef struct packed {
		logic [7:0] level;
		logic [1:0] tag;
		logic       last;
	} led_byte_t;

	// Tracks gamma tables, accumulators and noise; predicts the byte stream per pixel.
	class led_byte_scoreboard;
		bit          rgbw;
		bit          dither;
		logic [31:0] noise;
		logic [15:0] gamma_red [256];
		logic [15:0] gamma_green [256];
		logic [15:0] gamma_blue [256];
		int          acc [4][LED_COUNT];
		led_byte_t   bytes_due [$];
		int          errors;

		function new();
			rgbw   = 1'b0;
			dither = 1'b1;
			noise  = SEED_DEFAULT;
			errors = 0;
			for (int c = 0; c < 4; c++)
				for (int l = 0; l < LED_COUNT; l++)
					acc[c][l] = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_RGBW:   rgbw = val[0];
				REG_DITHER: dither = val[0];
				// a zero seed would lock the generator, so the default is taken
				REG_SEED:   noise = (val == 32'd0) ? SEED_DEFAULT : val;
				default: ;
			endcase
		endfunction

		function void advance_noise();
			noise = noise ^ (noise << 13);
			noise = noise ^ (noise >> 17);
			noise = noise ^ (noise << 5);
		endfunction

		// accumulate one channel level and return the byte it yields
		function logic [7:0] dither_channel(logic [1:0] ch, logic [9:0] led, logic [15:0] level);
			logic [31:0] v;
			longint      sum;
			int          acc_now;
			int          q;
			v = {16'd0, level};
			if (level > MID_LOW && level < MID_HIGH) begin
				advance_noise();
				v = v + {25'd0, noise[8:2]} - 32'd64;
			end
			sum = longint'(acc[ch][led]) + longint'(v);
			if (sum > longint'(ACC_MAX))
				sum = longint'(ACC_MAX);
			acc_now = int'(sum);
			acc[ch][led] = acc_now;
			q = acc_now >>> 8;
			if (q <= 0)
				return 8'd0;
			if (q >= 255) begin
				acc[ch][led] = acc_now - 65280;
				return 8'hFF;
			end
			acc[ch][led] = acc_now - q * 256;
			return q[7:0];
		endfunction

		function void note_item(pixel_item_t it);
			logic [15:0] vr, vg, vb, vw;
			logic [7:0]  br, bg, bb, bw;
			case (it.mode)
				MODE_LOAD: begin
					case (it.sel)
						SEL_RED:   gamma_red[it.index] = it.value;
						SEL_GREEN: gamma_green[it.index] = it.value;
						SEL_BLUE:  gamma_blue[it.index] = it.value;
						default: ;
					endcase
				end
				MODE_CLEAR: begin
					for (int c = 0; c < 4; c++)
						acc[c][it.led] = 0;
				end
				MODE_RENDER: begin
					vr = gamma_red[it.red];
					vg = gamma_green[it.green];
					vb = gamma_blue[it.blue];
					vw = 16'd0;
					bw = 8'd0;
					// move the common minimum into white
					if (rgbw) begin
						vw = (vr < vg) ? vr : vg;
						if (vb < vw)
							vw = vb;
						vr = vr - vw;
						vg = vg - vw;
						vb = vb - vw;
					end
					if (dither) begin
						br = dither_channel(CH_RED, it.led, vr);
						bg = dither_channel(CH_GREEN, it.led, vg);
						bb = dither_channel(CH_BLUE, it.led, vb);
						if (rgbw)
							bw = dither_channel(CH_WHITE, it.led, vw);
					end else begin
						br = vr[15:8];
						bg = vg[15:8];
						bb = vb[15:8];
						bw = vw[15:8];
					end
					bytes_due.push_back('{bb, TAG_BLUE, 1'b0});
					bytes_due.push_back('{br, TAG_RED, 1'b0});
					bytes_due.push_back('{bg, TAG_GREEN, !rgbw});
					if (rgbw)
						bytes_due.push_back('{bw, TAG_WHITE, 1'b1});
				end
				default: ;
			endcase
		endfunction

		function void check_byte(logic [7:0] level, logic [1:0] tag, logic last);
			led_byte_t want;
			if (bytes_due.size() == 0) begin
				$error("unexpected byte: out_byte %0d channel_tag %0d last_of_pixel %0b",
					level, tag, last);
				errors++;
				return;
			end
			want = bytes_due.pop_front();
			if (level !== want.level) begin
				$error("out_byte mismatch: expected %0d, got %0d", want.level, level);
				errors++;
			end
			if (tag !== want.tag) begin
				$error("channel_tag mismatch: expected %0d, got %0d", want.tag, tag);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_of_pixel mismatch: expected %0b, got %0b", want.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return bytes_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        pixel_valid;
	logic        pixel_stall;
	logic [1:0]  mode;
	logic [9:0]  led_index;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;
	logic [1:0]  table_select;
	logic [7:0]  table_index;
	logic [15:0] table_value;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  out_byte;
	logic [1:0]  channel_tag;
	logic        last_of_pixel;

	led_byte_scoreboard sb;
	bit gamma_written [3][256];
	bit quiet;
	bit steady_send;
	bit hold_request;

	led_gamma_dither_renderer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.pixel_valid   (pixel_valid),
		.pixel_stall   (pixel_stall),
		.mode          (mode),
		.led_index     (led_index),
		.red_in        (red_in),
		.green_in      (green_in),
		.blue_in       (blue_in),
		.table_select  (table_select),
		.table_index   (table_index),
		.table_value   (table_value),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.out_byte      (out_byte),
		.channel_tag   (channel_tag),
		.last_of_pixel (last_of_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("led_gamma_dither_renderer_tb: FAIL");
		$finish;
	end

	// mostly short gaps, a few long ones
	function int pick_gap(bit sender);
		int r;
		if (quiet || (sender && steady_send))
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function pixel_item_t make_item(logic [1:0] m, logic [9:0] led, logic [7:0] r,
			logic [7:0] g, logic [7:0] b, logic [1:0] sel, logic [7:0] idx,
			logic [15:0] val);
		pixel_item_t it;
		it.mode  = m;
		it.led   = led;
		it.red   = r;
		it.green = g;
		it.blue  = b;
		it.sel   = sel;
		it.index = idx;
		it.value = val;
		return it;
	endfunction

	// pick a gamma entry that has been loaded, leaning on the table ends
	function logic [7:0] pick_color(int sel);
		logic [7:0] c;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		do
			c = 8'($urandom_range(0, 255));
		while (!gamma_written[sel][c]);
		return c;
	endfunction

	function logic [15:0] pick_level();
		logic [15:0] edges [7];
		edges = '{16'd0, 16'd255, 16'd256, 16'd257, 16'd65278, 16'd65279, 16'd65535};
		if ($urandom_range(0, 4) == 0)
			return edges[$urandom_range(0, 6)];
		return 16'($urandom_range(0, 65535));
	endfunction

	function pixel_item_t random_item();
		pixel_item_t it;
		int r;
		it = pixel_item_t'(62'({$urandom, $urandom}));
		// a few LEDs get most of the traffic so the accumulators build up
		it.led = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
		                                     : 10'($urandom_range(0, 7));
		r = $urandom_range(0, 99);
		if (r < 60) begin
			it.mode  = MODE_RENDER;
			it.red   = pick_color(0);
			it.green = pick_color(1);
			it.blue  = pick_color(2);
		end else if (r < 85) begin
			it.mode  = MODE_LOAD;
			it.sel   = ($urandom_range(0, 19) == 0) ? SEL_NONE : 2'($urandom_range(0, 2));
			it.value = pick_level();
		end else if (r < 95) begin
			it.mode = MODE_CLEAR;
		end else begin
			it.mode = MODE_NONE;
		end
		return it;
	endfunction

	// offer one item and hold it until taken; entered and left at a falling edge
	task automatic send_item(pixel_item_t it);
		int gap;
		gap = pick_gap(1'b1);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (it.mode == MODE_LOAD && it.sel != SEL_NONE)
			gamma_written[it.sel][it.index] = 1'b1;
		mode         <= it.mode;
		led_index    <= it.led;
		red_in       <= it.red;
		green_in     <= it.green;
		blue_in      <= it.blue;
		table_select <= it.sel;
		table_index  <= it.index;
		table_value  <= it.value;
		pixel_valid  <= 1'b1;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// drop valid, wait for every byte, then let a trailing clear finish
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_random(int count);
		repeat (count) send_item(random_item());
	endtask

	task automatic directed_items();
		// table ends, mid-range edges and a few odd levels
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_RED, 8'd0, 16'd0));
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_RED, 8'd255, 16'hFFFF));
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_RED, 8'd1, 16'd257));
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_RED, 8'd2, 16'd65278));
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_GREEN, 8'd0, 16'd0));
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_GREEN, 8'd255, 16'hFFFF));
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_GREEN, 8'd1, 16'd256));
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_GREEN, 8'd2, 16'd65279));
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_BLUE, 8'd0, 16'd0));
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_BLUE, 8'd255, 16'hFFFF));
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_BLUE, 8'd1, 16'h1234));
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_BLUE, 8'd2, 16'd300));
		// select three must not touch any table
		send_item(make_item(MODE_LOAD, 0, 0, 0, 0, SEL_NONE, 8'd1, 16'hFFFF));
		send_item(make_item(MODE_RENDER, 10'd0, 8'd0, 8'd0, 8'd0, 0, 0, 0));
		send_item(make_item(MODE_RENDER, 10'd1023, 8'd255, 8'd255, 8'd255, 0, 0, 0));
		send_item(make_item(MODE_RENDER, 10'd3, 8'd1, 8'd1, 8'd1, 0, 0, 0));
		send_item(make_item(MODE_RENDER, 10'd3, 8'd1, 8'd1, 8'd1, 0, 0, 0));
		send_item(make_item(MODE_RENDER, 10'd3, 8'd2, 8'd2, 8'd2, 0, 0, 0));
		send_item(make_item(MODE_NONE, 10'd3, 8'd1, 8'd1, 8'd1, 0, 0, 0));
		send_item(make_item(MODE_RENDER, 10'd5, 8'd1, 8'd2, 8'd1, 0, 0, 0));
		send_item(make_item(MODE_CLEAR, 10'd3, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_RENDER, 10'd3, 8'd255, 8'd1, 8'd2, 0, 0, 0));
		send_item(make_item(MODE_CLEAR, 10'd1023, 0, 0, 0, 0, 0, 0));
	endtask

	// check every byte taken at a rising edge
	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall)
			sb.check_byte(out_byte, channel_tag, last_of_pixel);
	end

	// receiver stalls, with one long hold on request
	initial begin
		int stall_left;
		int n;
		stall_left = 0;
		byte_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				byte_stall <= 1'b1;
				stall_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				byte_stall <= 1'b1;
				stall_left = LONG_HOLD - 1;
			end else begin
				n = pick_gap(1'b0);
				byte_stall <= (n > 0);
				stall_left = (n > 0) ? n - 1 : 0;
			end
		end
	end

	initial begin
		bit          rgbw_plan [5];
		bit          dither_plan [5];
		logic [31:0] seed_plan [5];
		rgbw_plan    = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
		dither_plan  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
		seed_plan    = '{32'd1, 32'hFFFF_FFFF, 32'd0, $urandom, $urandom};
		sb           = new();
		quiet        = 1'b0;
		steady_send  = 1'b0;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pixel_valid  = 1'b0;
		mode         = MODE_RENDER;
		led_index    = '0;
		red_in       = '0;
		green_in     = '0;
		blue_in      = '0;
		table_select = SEL_RED;
		table_index  = '0;
		table_value  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings first
		directed_items();
		run_random(70);
		wait_idle();

		for (int p = 0; p < 5; p++) begin
			apb_write(REG_RGBW, {31'd0, rgbw_plan[p]});
			apb_write(REG_DITHER, {31'd0, dither_plan[p]});
			apb_write(REG_SEED, seed_plan[p]);
			// first phase fills the block behind a long receiver hold
			steady_send  = (p == 0);
			hold_request = (p == 0);
			quiet        = (p == 3);
			run_random(PHASE_ITEMS);
			steady_send = 1'b0;
			quiet       = 1'b0;
			wait_idle();
		end

		for (int n = 0; n < END_WAIT && sb.pending() != 0; n++)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected bytes never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("led_gamma_dither_renderer_tb: PASS");
		else
			$display("led_gamma_dither_renderer_tb: FAIL");
		$finish;
	end

endmodule
